// File: hdl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and constants of the triangle span rasterizer.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int CoordW     = 16;
  localparam int AddrW      = 16;
  localparam int ColW       = 12;
  localparam int ColorW     = 16;
  localparam int DivNumW    = CoordW + 5;  // dx*16 fits in 21 bits
  localparam int DivDenW    = CoordW + 1;  // dy fits in 17 bits
  localparam int RowStrideDefault = 128;

  localparam logic [1:0] PhaseDone  = 2'd0;
  localparam logic [1:0] PhaseUpper = 2'd1;
  localparam logic [1:0] PhaseLower = 2'd2;

  localparam logic KindLoad = 1'b0;
  localparam logic KindStep = 1'b1;

  localparam logic [11:0] SpanLenMax = 12'hfff;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vtx_t;

  // Divider status (busy, done) from the divide unit to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Subpixel prestep: distance from y up to the next whole row
  function automatic logic [3:0] prestep(input coord_t y);
    prestep = 4'(4'd0 - y[3:0]);
  endfunction

  // Signed multiply by prestep, divided by 16 truncating toward zero
  function automatic coord_t pre_mul(input logic [3:0] pre, input coord_t s);
    logic signed [20:0] p;
    logic signed [20:0] q;
    p = $signed({17'd0, pre}) * $signed({{5{s[CoordW-1]}}, s});
    q = p[20] ? (p + 21'sd15) >>> 4 : p >>> 4;
    pre_mul = q[CoordW-1:0];
  endfunction

endpackage

// File: hdl/tsr_ifs.sv
// ----------------------------------------------------------------------------
// tsr_ifs
// Valid/ready channel interfaces for vertex/step items and span items.
// ----------------------------------------------------------------------------
interface tsr_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  vertex_slot;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic [15:0] fill_color;
  modport source (output valid, kind, vertex_slot, vertex_x, vertex_y, fill_color,
                  input ready);
  modport sink (input valid, kind, vertex_slot, vertex_x, vertex_y, fill_color,
                output ready);
endinterface

interface tsr_out_if;
  logic        valid;
  logic        ready;
  logic        span_draw;
  logic [15:0] row_address;
  logic signed [11:0] span_start;
  logic [11:0] span_length;
  logic [15:0] span_color;
  logic        done_res;
  modport source (output valid, span_draw, row_address, span_start, span_length,
                  span_color, done_res, input ready);
  modport sink (input valid, span_draw, row_address, span_start, span_length,
                span_color, done_res, output ready);
endinterface

// File: hdl/tsr_div.sv
// ----------------------------------------------------------------------------
// tsr_div
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module tsr_div import tsr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [DivNumW-1:0] num,
  input  logic signed [DivDenW-1:0] den,
  output div_stat_t                 stat,
  output coord_t                    quot
);
  localparam int CntW = $clog2(DivNumW + 1);

  logic [DivNumW-1:0] quo;
  logic [DivDenW-1:0] rem;
  logic [DivDenW-1:0] dmag;
  logic [CntW-1:0]    cnt;
  logic               neg;
  logic               busy;
  logic               done;
  logic               zero;
  logic [DivDenW:0]   trial;
  logic [DivNumW-1:0] sq;

  assign trial = {rem, quo[DivNumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(DivNumW);
        quo  <= num[DivNumW-1] ? DivNumW'(-num) : num;
        dmag <= den[DivDenW-1] ? DivDenW'(-den) : den;
        rem  <= '0;
        neg  <= num[DivNumW-1] ^ den[DivDenW-1];
        zero <= (den == '0);
      end else if (busy) begin
        // shift one dividend bit in, subtract when it fits
        if (trial >= {1'b0, dmag}) begin
          rem <= DivDenW'(trial - {1'b0, dmag});
          quo <= {quo[DivNumW-2:0], 1'b1};
        end else begin
          rem <= trial[DivDenW-1:0];
          quo <= {quo[DivNumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sq   = neg ? DivNumW'(-quo) : quo;
  assign quot = zero ? '0 : sq[CoordW-1:0];
  assign stat = '{busy: busy, done: done};

endmodule

// File: hdl/triangle_span_rasterizer_top.sv
// ----------------------------------------------------------------------------
// triangle_span_rasterizer_top
// Sorts three 12.4 vertices, derives edge slopes and walks one span per step.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | item
//  in_ch   | in  | valid/ready      | vertex load or step request
//  out_ch  | out | valid/ready      | span of one scanline (steps only)
//  cfg     | in  | cfg_we, no wait  | frame_base register
//
//  A step request's result sits in an output register and the next item is
//  taken once that result has gone.
//  A load to slot 2 starts set-up: a sort, three divides on the shared
//  restoring divider, the three prestep products on the shared prestep
//  multiplier and a finish step.
//  rst is synchronous; it returns the walk to done and clears control state.
// ----------------------------------------------------------------------------
module triangle_span_rasterizer_top import tsr_pkg::*; #(
  parameter int ROW_STRIDE = RowStrideDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data,
  tsr_in_if.sink         in_ch,
  tsr_out_if.source      out_ch
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SORT   = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DWAIT  = 3'd3;
  localparam logic [2:0] S_PRE    = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  localparam logic [AddrW-1:0] Stride = AddrW'(ROW_STRIDE);

  logic [2:0]  state;
  logic [1:0]  sidx;
  logic [15:0] frame_base;
  vtx_t        v0, v1, v2;
  vtx_t        vt, vm, vb;
  logic [1:0]  ti, mi, bi;
  logic        ml;
  logic [15:0] color;
  coord_t      ledge, redge, s12, s13, s23;
  coord_t      cy, pe, lys, ley, lxs;
  logic [1:0]  phase;
  logic [AddrW-1:0] addr;

  // output register
  logic        ovalid;
  logic        o_draw, o_done;
  logic [15:0] o_addr, o_color;
  logic [11:0] o_start, o_len;

  logic in_fire;
  assign in_ch.ready = (state == S_IDLE) && !ovalid;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // select a vertex by its slot number
  function automatic vtx_t pick(input logic [1:0] i, input vtx_t a, input vtx_t b,
                                input vtx_t c);
    unique case (i)
      2'd0:    pick = a;
      2'd1:    pick = b;
      default: pick = c;
    endcase
  endfunction

  assign vt = pick(ti, v0, v1, v2);
  assign vm = pick(mi, v0, v1, v2);
  assign vb = pick(bi, v0, v1, v2);

  // sort by y with strict compares; middle goes left on even permutations
  logic [1:0] st, sm, sb;
  logic       sml;
  always_comb begin
    if (v0.y < v1.y) begin
      if (v2.y < v0.y) begin
        st = 2'd2; sm = 2'd0; sb = 2'd1; sml = 1'b1;
      end else if (v1.y < v2.y) begin
        st = 2'd0; sm = 2'd1; sb = 2'd2; sml = 1'b1;
      end else begin
        st = 2'd0; sm = 2'd2; sb = 2'd1; sml = 1'b0;
      end
    end else begin
      if (v2.y < v1.y) begin
        st = 2'd2; sm = 2'd1; sb = 2'd0; sml = 1'b0;
      end else if (v0.y < v2.y) begin
        st = 2'd1; sm = 2'd0; sb = 2'd2; sml = 1'b0;
      end else begin
        st = 2'd1; sm = 2'd2; sb = 2'd0; sml = 1'b1;
      end
    end
  end

  // shared divider: edge top-middle, top-bottom, middle-bottom by sidx
  vtx_t       da, db;
  div_stat_t  dstat;
  coord_t     dquot;
  logic signed [DivNumW-1:0] dnum;
  logic signed [DivDenW-1:0] dden;
  always_comb begin
    unique case (sidx)
      2'd0:    begin da = vt; db = vm; end
      2'd1:    begin da = vt; db = vb; end
      default: begin da = vm; db = vb; end
    endcase
  end
  assign dden = DivDenW'($signed(db.y)) - DivDenW'($signed(da.y));
  assign dnum = (DivNumW'($signed(db.x)) - DivNumW'($signed(da.x))) <<< 4;

  tsr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DSTART),
    .num   (dnum),
    .den   (dden),
    .stat  (dstat),
    .quot  (dquot)
  );

  // shared prestep multiplier
  logic [3:0] pre_t, pre_m, pre_b, mpre;
  coord_t     mslope, mbase, mres;
  assign pre_t = prestep(vt.y);
  assign pre_m = prestep(vm.y);
  assign pre_b = prestep(vb.y);
  always_comb begin
    unique case (sidx)
      2'd0:    begin mpre = pre_t; mbase = vt.x; mslope = ml ? s12 : s13; end
      2'd1:    begin mpre = pre_t; mbase = vt.x; mslope = ml ? s13 : s12; end
      default: begin mpre = pre_m; mbase = vm.x; mslope = s23; end
    endcase
  end
  assign mres = coord_t'(mbase + pre_mul(mpre, mslope));

  // finish values of set-up
  coord_t cy_fin;
  logic signed [11:0] row_idx;
  logic [27:0]        row_off;
  assign cy_fin  = coord_t'(vt.y + $signed({12'd0, pre_t}));
  assign row_idx = cy_fin[15:4];
  assign row_off = 28'({{16{row_idx[11]}}, row_idx}) * 28'(ROW_STRIDE);

  // one scanline step advances edges and y, set-up finish loads the start values; then settle the phase
  coord_t ledge_s, redge_s, cy_s, pe_s, ledge_n, redge_n, cy_n, pe_n;
  logic [1:0] ph_s, ph_n;
  always_comb begin
    if (state == S_FIN) begin
      ph_s    = PhaseUpper;
      cy_s    = cy_fin;
      pe_s    = coord_t'(vm.y + $signed({12'd0, pre_m}));
      ledge_s = ledge;
      redge_s = redge;
    end else begin
      ph_s    = phase;
      cy_s    = coord_t'(cy + 16'sd16);
      pe_s    = pe;
      if (phase == PhaseUpper) begin
        ledge_s = coord_t'(ledge + (ml ? s12 : s13));
        redge_s = coord_t'(redge + (ml ? s13 : s12));
      end else begin
        ledge_s = coord_t'(ledge + (ml ? s23 : s13));
        redge_s = coord_t'(redge + (ml ? s13 : s23));
      end
    end
    ph_n = ph_s; cy_n = cy_s; pe_n = pe_s; ledge_n = ledge_s; redge_n = redge_s;
    // leave the upper half, swap in the lower edge
    if (ph_n == PhaseUpper && !(cy_n < pe_n)) begin
      cy_n = lys;
      pe_n = ley;
      if (ml) ledge_n = lxs;
      else    redge_n = lxs;
      ph_n = PhaseLower;
    end
    if (ph_n == PhaseLower && !(cy_n < pe_n)) ph_n = PhaseDone;
  end

  // span columns from the current edges
  logic signed [16:0] lsum, rsum;
  logic signed [12:0] sx, sx2;
  logic signed [13:0] len;
  assign lsum = 17'($signed(ledge)) + 17'sd15;
  assign rsum = 17'($signed(redge)) + 17'sd15;
  assign sx   = 13'(lsum >>> 4);
  assign sx2  = 13'(rsum >>> 4);
  assign len  = 14'($signed(sx2)) - 14'($signed(sx));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sidx <= '0;
      phase <= PhaseDone;
      ovalid <= 1'b0;
      frame_base <= '0;
      color <= '0; ledge <= '0; redge <= '0;
      s12 <= '0; s13 <= '0; s23 <= '0;
      cy <= '0; pe <= '0; lys <= '0; ley <= '0; lxs <= '0;
      ml <= 1'b0; addr <= '0;
      ti <= '0; mi <= '0; bi <= '0;
    end else begin
      if (cfg_we) frame_base <= cfg_data;
      if (ovalid && out_ch.ready) ovalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire && in_ch.kind == KindLoad) begin
            // slot three is dropped
            unique case (in_ch.vertex_slot)
              2'd0: v0 <= '{x: in_ch.vertex_x, y: in_ch.vertex_y};
              2'd1: v1 <= '{x: in_ch.vertex_x, y: in_ch.vertex_y};
              2'd2: begin
                v2    <= '{x: in_ch.vertex_x, y: in_ch.vertex_y};
                color <= in_ch.fill_color;
                state <= S_SORT;
              end
              default: ;
            endcase
          end else if (in_fire) begin
            ovalid <= 1'b1;
            if (phase == PhaseDone) begin
              o_draw  <= 1'b0;
              o_addr  <= '0;
              o_start <= '0;
              o_len   <= '0;
              o_color <= '0;
              o_done  <= 1'b1;
            end else begin
              o_addr <= addr;
              if (sx < sx2) begin
                o_draw  <= 1'b1;
                o_start <= sx[11:0];
                o_len   <= (len > 14'sd4095) ? SpanLenMax : len[11:0];
                o_color <= color;
              end else begin
                o_draw  <= 1'b0;
                o_start <= '0;
                o_len   <= '0;
                o_color <= '0;
              end
              addr  <= addr + Stride;
              ledge <= ledge_n;
              redge <= redge_n;
              cy    <= cy_n;
              pe    <= pe_n;
              phase <= ph_n;
              o_done <= (ph_n == PhaseDone);
            end
          end
        end
        S_SORT: begin
          ti <= st; mi <= sm; bi <= sb; ml <= sml;
          sidx <= '0;
          // zero height: nothing to walk
          if (pick(sb, v0, v1, v2).y == pick(st, v0, v1, v2).y) begin
            phase <= PhaseDone;
            state <= S_IDLE;
          end else begin
            state <= S_DSTART;
          end
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (dstat.done) begin
            unique case (sidx)
              2'd0:    s12 <= dquot;
              2'd1:    s13 <= dquot;
              default: s23 <= dquot;
            endcase
            if (sidx == 2'd2) begin
              sidx  <= '0;
              state <= S_PRE;
            end else begin
              sidx  <= sidx + 1'b1;
              state <= S_DSTART;
            end
          end
        end
        S_PRE: begin
          unique case (sidx)
            2'd0:    ledge <= mres;
            2'd1:    redge <= mres;
            default: lxs <= mres;
          endcase
          if (sidx == 2'd2) begin
            sidx  <= '0;
            lys   <= coord_t'(vm.y + $signed({12'd0, pre_m}));
            ley   <= coord_t'(vb.y + $signed({12'd0, pre_b}));
            state <= S_FIN;
          end else begin
            sidx <= sidx + 1'b1;
          end
        end
        S_FIN: begin
          addr  <= frame_base + row_off[AddrW-1:0];
          cy    <= cy_n;
          pe    <= pe_n;
          ledge <= ledge_n;
          redge <= redge_n;
          phase <= ph_n;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = ovalid;
  assign out_ch.span_draw   = o_draw;
  assign out_ch.row_address = o_addr;
  assign out_ch.span_start  = o_start;
  assign out_ch.span_length = o_len;
  assign out_ch.span_color  = o_color;
  assign out_ch.done_res    = o_done;

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    dstat.done |-> state == S_DWAIT) else $error("divider finished outside wait");
  a_slot2_starts_setup: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.kind == KindLoad && in_ch.vertex_slot == 2'd2 |=> state == S_SORT)
    else $error("slot 2 load did not start set-up");
  a_sidx_range: assert property (@(posedge clk) disable iff (rst)
    sidx != 2'd3) else $error("set-up step index out of range");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3) else $error("walk phase code invalid");

endmodule
